[design/tcas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcas_pkg
// Widths, register indexes and the 2^-x table for the tilt-compensated
// rumble intensity pipeline.
// ----------------------------------------------------------------------------
package tcas_pkg;

	localparam int ACCEL_FRAC_BITS_DEF = 8;
	localparam int OUT_BITS_DEF        = 16;

	localparam int QUAT_W  = 16;
	localparam int ACCEL_W = 16;
	localparam int GAIN_W  = 16;
	localparam int MID_W   = 16;
	localparam int OUT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MID  = 1'b1;

	localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd256;
	localparam logic [MID_W-1:0]         MID_RST  = 16'd1280;

	// magnitude of the gravity-compensated acceleration and root sizing
	localparam int EX_W    = 24;
	localparam int ROOT_N  = 25;
	localparam int ROOT_VW = 2 * ROOT_N;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [20:0] T_LIMIT   = 21'd1048576;
	localparam logic [16:0] ONE_Q16   = 17'd65536;

	// 2^-(i/16) in Q16
	function automatic logic [16:0] pow2_neg(input logic [4:0] i);
		logic [16:0] v;
		unique case (i)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage

[design/tcas_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcas_if
// Stream interfaces: IMU sample in, rumble intensity out.
// ----------------------------------------------------------------------------
interface tcas_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, accel_x, accel_y,
		input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, accel_x, accel_y,
		output ready);
endinterface

interface tcas_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] intensity;

	modport source (output valid, intensity, input ready);
	modport sink (input valid, intensity, output ready);
endinterface

[design/tilt_compensated_accel_sigmoid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_accel_sigmoid_unit
// Gravity-compensated horizontal acceleration mapped to a rumble intensity.
// ----------------------------------------------------------------------------
// Takes one IMU sample per cycle and returns one intensity per sample, in
// order. The pipeline holds a bit-per-stage square root and a bit-per-stage
// divider for the final sigmoid quotient. The whole pipeline holds while
// the output transfer is stalled. gain and the midpoint are read directly
// by the later stages, so write them only while the pipeline is
// empty.
module tilt_compensated_accel_sigmoid_unit
	import tcas_pkg::*;
#(
	parameter int ACCEL_FRAC_BITS = ACCEL_FRAC_BITS_DEF,
	parameter int OUT_BITS        = OUT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	tcas_in_if.sink              sample,
	tcas_out_if.source           result
);

	localparam int GRAV   = (981 * (1 << ACCEL_FRAC_BITS) + 50) / 100;
	localparam logic signed [16:0] NEG_G = 17'(-GRAV);
	localparam int T_SH   = 16 - ACCEL_FRAC_BITS;
	localparam int PROD_W = 42;
	localparam int TV_W   = PROD_W + T_SH;
	localparam int DIV_N  = OUT_BITS + 1;
	localparam int NST    = 6 + ROOT_N + 5 + DIV_N + 1;
	localparam logic [16:0] FULL = 17'((1 << OUT_BITS) - 1);

	logic signed [GAIN_W-1:0] gain_q;
	logic [MID_W-1:0]         mid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			mid_q  <= MID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN: gain_q <= $signed(cfg_data);
				CFG_MID:  mid_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic           ce;
	logic [NST-1:0] vld_q;

	assign ce           = !vld_q[NST-1] || result.ready;
	assign sample.ready = ce;
	assign result.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[NST-2:0], sample.valid};
		end
	end

	// s1: quaternion products
	logic signed [31:0] p_xz_s1, p_wy_s1, p_yz_s1, p_wx_s1;
	logic signed [15:0] ax_s1, ay_s1;
	// s2: gravity terms before rounding
	logic signed [50:0] gxp_s2, gyp_s2;
	logic signed [15:0] ax_s2, ay_s2;
	// s3: rounded gravity
	logic signed [23:0] gx_s3, gy_s3;
	logic signed [15:0] ax_s3, ay_s3;
	// s4..s6: magnitude squared
	logic [EX_W-1:0]    ux_s4, uy_s4;
	logic [2*EX_W-1:0]  sx_s5, sy_s5;
	logic [ROOT_VW-1:0] sum_s6;

	logic signed [32:0] dgx, dgy;
	logic signed [50:0] gxm, gym, gxa, gya;
	logic [22:0]        gxr, gyr;
	logic signed [24:0] ex, ey;

	always_comb begin
		dgx = 33'(p_xz_s1) - 33'(p_wy_s1);
		dgy = 33'(p_yz_s1) + 33'(p_wx_s1);
		gxm = 51'($signed({dgx, 1'b0})) * 51'(NEG_G);
		gym = 51'($signed({dgy, 1'b0})) * 51'(NEG_G);
		gxa = gxp_s2[50] ? -gxp_s2 : gxp_s2;
		gya = gyp_s2[50] ? -gyp_s2 : gyp_s2;
		gxr = 23'((gxa + 51'sd134217728) >>> 28);
		gyr = 23'((gya + 51'sd134217728) >>> 28);
		ex  = 25'(ax_s3) - 25'(gx_s3);
		ey  = 25'(ay_s3) - 25'(gy_s3);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			p_xz_s1 <= sample.quat_x * sample.quat_z;
			p_wy_s1 <= sample.quat_w * sample.quat_y;
			p_yz_s1 <= sample.quat_y * sample.quat_z;
			p_wx_s1 <= sample.quat_w * sample.quat_x;
			ax_s1   <= sample.accel_x;
			ay_s1   <= sample.accel_y;
			gxp_s2  <= gxm;
			gyp_s2  <= gym;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			gx_s3   <= gxp_s2[50] ? -$signed({1'b0, gxr}) : $signed({1'b0, gxr});
			gy_s3   <= gyp_s2[50] ? -$signed({1'b0, gyr}) : $signed({1'b0, gyr});
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			ux_s4   <= EX_W'(ex[24] ? -ex : ex);
			uy_s4   <= EX_W'(ey[24] ? -ey : ey);
			sx_s5   <= ux_s4 * ux_s4;
			sy_s5   <= uy_s4 * uy_s4;
			sum_s6  <= ROOT_VW'(sx_s5) + ROOT_VW'(sy_s5);
		end
	end

	// square root, one result bit per stage
	logic [ROOT_VW-1:0] rt_rem_s [ROOT_N];
	logic [ROOT_VW-1:0] rt_res_s [ROOT_N];

	for (genvar k = 0; k < ROOT_N; k++) begin : g_root
		localparam logic [ROOT_VW-1:0] BIT = ROOT_VW'(1) << (2 * (ROOT_N - 1 - k));
		logic [ROOT_VW-1:0] rem_in, res_in, trial;
		always_comb begin
			rem_in = (k == 0) ? sum_s6 : rt_rem_s[(k == 0) ? 0 : k - 1];
			res_in = (k == 0) ? '0 : rt_res_s[(k == 0) ? 0 : k - 1];
			trial  = res_in + BIT;
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				if (rem_in >= trial) begin
					rt_rem_s[k] <= rem_in - trial;
					rt_res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rt_rem_s[k] <= rem_in;
					rt_res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	// sigmoid exponent and exp(-|t|)
	logic signed [PROD_W-1:0] prod_sd;
	logic [20:0]              a_se;
	logic                     neg_se, neg_sf, neg_sg;
	logic [22:0]              y_sf;
	logic [16:0]              tv_sg;
	logic [6:0]               n_sg;
	logic [34:0]              num_sh;
	logic [17:0]              den_sh;

	logic signed [25:0]       diff;
	logic signed [TV_W-1:0]   tw, tmag;
	logic [TV_W-1:0]          tr;
	logic [38:0]              yw;
	logic [16:0]              t_i, t_n, dlt, e;
	logic [28:0]              pr;
	logic [17:0]              den;

	always_comb begin
		diff = $signed({1'b0, rt_res_s[ROOT_N-1][ROOT_N-1:0]}) - $signed({10'b0, mid_q});
		tw   = TV_W'(prod_sd) <<< T_SH;
		tmag = tw[TV_W-1] ? -tw : tw;
		tr   = TV_W'((tmag + TV_W'(128)) >>> 8);
		yw   = 39'(a_se) * 39'(LOG2E_Q16) + 39'd32768;
		t_i  = pow2_neg({1'b0, y_sf[15:12]});
		t_n  = pow2_neg(5'({1'b0, y_sf[15:12]}) + 5'd1);
		dlt  = t_i - t_n;
		pr   = 29'(dlt) * 29'(y_sf[11:0]);
		e    = tv_sg >> n_sg;
		den  = 18'(ONE_Q16) + 18'(e);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_sd <= PROD_W'(gain_q) * PROD_W'(diff);
			a_se    <= (tr > TV_W'(T_LIMIT)) ? T_LIMIT : tr[20:0];
			neg_se  <= prod_sd[PROD_W-1];
			y_sf    <= yw[38:16];
			neg_sf  <= neg_se;
			tv_sg   <= t_i - 17'((30'(pr) + 30'd2048) >> 12);
			n_sg    <= y_sf[22:16];
			neg_sg  <= neg_sf;
			num_sh  <= 35'(neg_sg ? e : ONE_Q16) * 35'(FULL) + 35'(den >> 1);
			den_sh  <= den;
		end
	end

	// divider, one quotient bit per stage
	logic [34:0]      dv_rem_s [DIV_N];
	logic [17:0]      dv_den_s [DIV_N];
	logic [DIV_N-1:0] dv_q_s   [DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		localparam int SH = DIV_N - 1 - k;
		logic [34:0]      rem_in, sub;
		logic [17:0]      den_in;
		logic [DIV_N-1:0] q_in;
		always_comb begin
			rem_in = (k == 0) ? num_sh : dv_rem_s[(k == 0) ? 0 : k - 1];
			den_in = (k == 0) ? den_sh : dv_den_s[(k == 0) ? 0 : k - 1];
			q_in   = (k == 0) ? '0 : dv_q_s[(k == 0) ? 0 : k - 1];
			sub    = 35'(den_in) << SH;
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				dv_den_s[k] <= den_in;
				if (rem_in >= sub) begin
					dv_rem_s[k] <= rem_in - sub;
					dv_q_s[k]   <= q_in | (DIV_N'(1) << SH);
				end else begin
					dv_rem_s[k] <= rem_in;
					dv_q_s[k]   <= q_in;
				end
			end
		end
	end

	logic [OUT_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (ce) begin
			out_q <= (17'(dv_q_s[DIV_N-1]) > FULL) ? OUT_W'(FULL)
				: OUT_W'(dv_q_s[DIV_N-1]);
		end
	end

	assign result.intensity = out_q;

endmodule

[design/tcas_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcas_checker
// Port-level checks on the intensity pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tcas_checker #(
	parameter int OUT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] intensity
);

	// pipeline moves whenever the output slot is free or being taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (17'(intensity) <= 17'((1 << OUT_BITS) - 1)))
		else $error("intensity above full scale");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(intensity))
		else $error("stalled result changed");

	a_rst: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind tilt_compensated_accel_sigmoid_unit tcas_checker #(.OUT_BITS(OUT_BITS)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.intensity (result.intensity)
);

[tb/tcas_intensity_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcas_intensity_checker
// Watches the sample and intensity channels and the register port, works out
// the rumble intensity of every accepted sample and compares it, in order,
// with the intensity that the block returns.
// ----------------------------------------------------------------------------
module tcas_intensity_checker
	import tcas_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	tcas_in_if                   sample,
	tcas_out_if                  result,
	output int                   fail_count,
	output int                   outstanding
);

	localparam longint GRAV = 2511;	// round(9.81 * 256)
	localparam longint FULL = 65535;
	localparam longint TLIM = 1048576;

	longint unsigned pow2_tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
		50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

	logic signed [GAIN_W-1:0] gain_reg;
	logic [MID_W-1:0]         mid_reg;
	logic [OUT_W-1:0]         intensity_q [$];

	function automatic longint rnd_shift(input longint v, input int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned acc, bitv;
		acc  = 0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= acc + bitv) begin
				v   = v - (acc + bitv);
				acc = (acc >> 1) + bitv;
			end else begin
				acc = acc >> 1;
			end
			bitv = bitv >> 2;
		end
		return acc;
	endfunction

	// exp(-a), a and result in Q16
	function automatic longint unsigned exp_neg(input longint unsigned a);
		longint unsigned y, n, f, idx, r, v;
		y   = (a * 94548 + 32768) >> 16;
		n   = y >> 16;
		f   = y & 64'hFFFF;
		idx = f >> 12;
		r   = f & 64'hFFF;
		v   = pow2_tab[idx] - (((pow2_tab[idx] - pow2_tab[idx+1]) * r + 2048) >> 12);
		if (n > 31)
			return 0;
		return v >> n;
	endfunction

	function automatic logic [OUT_W-1:0] rumble_level(
		input logic signed [15:0] qx, qy, qz, qw, ax, ay,
		input logic signed [GAIN_W-1:0] g, input logic [MID_W-1:0] mid);
		longint gx, gy, ex, ey, t, m;
		longint unsigned ux, uy, e, num, den, res;
		gx = rnd_shift(2 * (longint'(qx) * qz - longint'(qw) * qy) * (-GRAV), 28);
		gy = rnd_shift(2 * (longint'(qy) * qz + longint'(qw) * qx) * (-GRAV), 28);
		ex = longint'(ax) - gx;
		ey = longint'(ay) - gy;
		ux = (ex < 0) ? -ex : ex;
		uy = (ey < 0) ? -ey : ey;
		m  = longint'(int_root(ux * ux + uy * uy));
		t  = rnd_shift(longint'(g) * (m - longint'(mid)) * 256, 8);
		if (t > TLIM)
			t = TLIM;
		if (t < -TLIM)
			t = -TLIM;
		e   = exp_neg((t < 0) ? -t : t);
		num = (t >= 0) ? 65536 : e;
		den = 65536 + e;
		res = (num * FULL + den / 2) / den;
		if (res > FULL)
			res = FULL;
		return res[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			gain_reg    <= GAIN_RST;
			mid_reg     <= MID_RST;
			fail_count  <= 0;
			outstanding <= 0;
			intensity_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN: gain_reg <= signed'(cfg_data);
					CFG_MID:  mid_reg  <= cfg_data;
					default: ;
				endcase
			end
			if (sample.valid && sample.ready)
				intensity_q.push_back(rumble_level(sample.quat_x, sample.quat_y,
					sample.quat_z, sample.quat_w, sample.accel_x, sample.accel_y,
					gain_reg, mid_reg));
			if (result.valid && result.ready) begin
				if (intensity_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected intensity %0d with nothing pending",
							result.intensity);
					fail_count <= fail_count + 1;
				end else begin
					want = intensity_q.pop_front();
					if (want !== result.intensity) begin
						if (fail_count < 10)
							$display("intensity mismatch: expected %0d, got %0d",
								want, result.intensity);
						fail_count <= fail_count + 1;
					end
				end
			end
			outstanding <= intensity_q.size();
		end
	end

endmodule

[tb/tb_tilt_compensated_accel_sigmoid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_compensated_accel_sigmoid_unit
// Drives directed and random IMU samples through the rumble pipeline over
// several gain and mid-point settings and handshake loads; the checker
// predicts each intensity and counts mismatches.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_accel_sigmoid_unit;
	import tcas_pkg::*;

	localparam int LATENCY   = 54;
	localparam int CYC_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   outstanding;
	int                   cycles = 0;
	int                   idle_pct;
	int                   stall_pct;

	tcas_in_if  sample ();
	tcas_out_if result ();

	tilt_compensated_accel_sigmoid_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample.sink),
		.result    (result.source)
	);

	tcas_intensity_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk)
		result.ready <= ($urandom_range(99) >= stall_pct);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// called at a falling edge; returns at a falling edge after the transfer
	task automatic send_sample(input logic signed [15:0] qx, qy, qz, qw, ax, ay);
		while ($urandom_range(99) < idle_pct) begin
			sample.valid = 1'b0;
			@(negedge clk);
		end
		sample.valid   = 1'b1;
		sample.quat_x  = qx;
		sample.quat_y  = qy;
		sample.quat_z  = qz;
		sample.quat_w  = qw;
		sample.accel_x = ax;
		sample.accel_y = ay;
		// ready is taken as it stood at the edge, before that edge's updates
		@(posedge clk iff sample.ready);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_quat();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				// small horizontal motion near the midpoint keeps the sigmoid off its rails
				send_sample(0, 0, 0, 16384, 16'($signed($urandom_range(2000)) - 1000),
					16'($signed($urandom_range(2000)) - 1000));
			else
				send_sample(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
					16'($urandom), 16'($urandom));
		end
	endtask

	task automatic drain();
		sample.valid = 1'b0;
		while (outstanding != 0 || result.valid) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	initial begin
		logic [15:0] gains [6] = '{16'd256, 16'h7FFF, 16'h8000, 16'd0, 16'hFF00, 16'd40};
		logic [15:0] mids  [6] = '{16'd1280, 16'd0, 16'hFFFF, 16'd700, 16'd2000, 16'd300};
		int idles  [4] = '{0, 76, 0, 18};
		int stalls [4] = '{0, 0, 76, 18};
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_GAIN;
		cfg_data       = '0;
		idle_pct       = 0;
		stall_pct      = 0;
		sample.valid   = 1'b0;
		sample.quat_x  = '0;
		sample.quat_y  = '0;
		sample.quat_z  = '0;
		sample.quat_w  = '0;
		sample.accel_x = '0;
		sample.accel_y = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: level, tilted, extremes, non-unit quaternions
		send_sample(0, 0, 0, 16384, 0, 0);
		send_sample(0, 0, 0, 16384, 1280, 0);
		send_sample(0, 0, 0, 16384, 32767, 32767);
		send_sample(0, 0, 0, 16384, -32768, -32768);
		send_sample(0, 0, 0, -16384, 32767, -32768);
		send_sample(16384, 0, 0, 0, 0, 0);
		send_sample(0, 16384, 0, 0, 0, 0);
		send_sample(0, 0, 16384, 0, 0, 0);
		send_sample(11585, 0, 0, 11585, 0, 0);
		send_sample(0, 11585, 0, 11585, 0, 0);
		send_sample(16384, 16384, 16384, 16384, 0, 0);
		send_sample(-16384, -16384, -16384, -16384, -32768, 32767);
		send_sample(16384, -16384, 16384, -16384, 32767, -32768);
		send_sample(0, 0, 0, 0, 0, 0);
		send_sample(0, 0, 0, 0, 1279, 1);
		send_sample(-16384, 16384, -16384, 16384, 1, -1);

		for (int p = 0; p < 6; p++) begin
			drain();
			write_reg(CFG_GAIN, gains[p]);
			write_reg(CFG_MID, mids[p]);
			idle_pct  = idles[p % 4];
			stall_pct = stalls[p % 4];
			if (p == 3)
				send_sample(0, 0, 0, 16384, 0, 0);	// zero gain: half scale
			send_random(215);
		end
		drain();
		write_reg(CFG_GAIN, 16'($urandom));
		write_reg(CFG_MID, 16'($urandom_range(3000)));
		idle_pct  = 18;
		stall_pct = 18;
		send_random(100);
		drain();

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
